// File: rtl/mm4_pkg.sv
package mm4_pkg;

	localparam int DIM      = 4;
	localparam int IDX_W    = 2;
	localparam int ADDR_W   = $clog2(DIM * DIM);
	localparam int VAL_W    = 32;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_W    = PROD_W + $clog2(DIM);
	localparam int FRAC_W   = 16;
	localparam int FUNC_W   = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD_LEFT  = 2'd0,
		FN_LOAD_RIGHT = 2'd1,
		FN_COMPUTE    = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic [IDX_W-1:0] wr_row;
		logic [IDX_W-1:0] wr_col;
		logic [VAL_W-1:0] wr_data;
		logic             mac_valid;
		logic             mac_first;
		logic             mac_last;
		logic             elem_last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_full;
	} status_t;

endpackage

// File: rtl/matrix_multiply_4x4_unit.sv
// 4x4 matrix multiplier, signed Q16.16. A word with tuser 0 or 1 writes one element of the
// left or right matrix at (row, col); both matrices are zero after reset.
// A word with tuser 2 streams out the 16 elements of left * right, column by column and row
// by row within a column, tlast on the final one; each element is the exact sum of four
// Q32.32 products, floored to Q16.16 and saturated. Every element runs four steps through one
// shared 32x32 multiplier, then drains into the single output register, and the next element
// starts only once that register is free. No input word is taken while a product is being
// formed; a tuser code of 3 is dropped.
module matrix_multiply_4x4_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mm4_pkg::S_DATA_W-1:0]    s_tdata,  // row_index[1:0], col_index[3:2],
	                                                  // element_value[35:4], zero[39:36]
	input  logic [mm4_pkg::FUNC_W-1:0]      s_tuser,  // func[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mm4_pkg::M_DATA_W-1:0]    m_tdata,  // out_row[1:0], out_col[3:2],
	                                                  // product_value[35:4], zero[39:36]
	output logic                            m_tlast
);
	import mm4_pkg::*;

	cmd_t                    cmd;
	status_t                 status;
	logic [IDX_W-1:0]        out_row, out_col;
	logic signed [VAL_W-1:0] product_value;

	mm4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_func  (s_tuser),
		.in_row   (s_tdata[IDX_W-1:0]),
		.in_col   (s_tdata[2*IDX_W-1:IDX_W]),
		.in_value (s_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
		.status   (status),
		.cmd      (cmd)
	);

	mm4_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.last_element  (m_tlast)
	);

	assign m_tdata = {(M_DATA_W - 2*IDX_W - VAL_W)'(0), product_value, out_col, out_row};

endmodule

// File: rtl/mm4_ctrl.sv
module mm4_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mm4_pkg::FUNC_W-1:0]          in_func,
	input  logic [mm4_pkg::IDX_W-1:0]           in_row,
	input  logic [mm4_pkg::IDX_W-1:0]           in_col,
	input  logic [mm4_pkg::VAL_W-1:0]           in_value,
	input  mm4_pkg::status_t                    status,
	output mm4_pkg::cmd_t                       cmd
);
	import mm4_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] row_q, col_q, k_q;
	logic             accept;
	logic             in_range;
	logic             k_end, row_end, col_end;

	assign k_end   = (k_q == IDX_W'(DIM - 1));
	assign row_end = (row_q == IDX_W'(DIM - 1));
	assign col_end = (col_q == IDX_W'(DIM - 1));
	assign in_range = ({1'b0, in_row} < (IDX_W + 1)'(DIM)) &&
	                  ({1'b0, in_col} < (IDX_W + 1)'(DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					k_q   <= '0;
				end
				ST_ISSUE: begin
					k_q <= k_end ? '0 : k_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						if (row_end) begin
							row_q <= '0;
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = (state_q == ST_IDLE);
		accept        = s_tvalid && s_tready;
		cmd           = '0;
		cmd.wr_row    = in_row;
		cmd.wr_col    = in_col;
		cmd.wr_data   = in_value;
		cmd.row       = row_q;
		cmd.col       = col_q;
		cmd.k         = k_q;
		cmd.mac_first = (k_q == '0);
		cmd.mac_last  = k_end;
		cmd.elem_last = row_end && col_end;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_t'(in_func))
						FN_LOAD_LEFT:  cmd.wr_left  = in_range;
						FN_LOAD_RIGHT: cmd.wr_right = in_range;
						FN_COMPUTE:    state_d      = ST_START;
						default:       ;
					endcase
				end
			end
			ST_START: begin
				if (!status.out_full) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.mac_valid = 1'b1;
				if (k_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = (row_end && col_end) ? ST_IDLE : ST_START;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/mm4_datapath.sv
module mm4_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mm4_pkg::cmd_t                 cmd,
	output mm4_pkg::status_t              status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mm4_pkg::IDX_W-1:0]     out_row,
	output logic [mm4_pkg::IDX_W-1:0]     out_col,
	output logic signed [mm4_pkg::VAL_W-1:0] product_value,
	output logic                          last_element
);
	import mm4_pkg::*;

	localparam int SH_W = ACC_W - FRAC_W;

	logic [VAL_W-1:0]         left_q  [DIM*DIM];
	logic [VAL_W-1:0]         right_q [DIM*DIM];

	logic [ADDR_W-1:0]        wr_addr, left_addr, right_addr;

	logic                     valid_s1, first_s1, last_s1, elast_s1;
	logic [IDX_W-1:0]         row_s1, col_s1;
	logic signed [VAL_W-1:0]  a_s1, b_s1;

	logic                     valid_s2, first_s2, last_s2, elast_s2;
	logic [IDX_W-1:0]         row_s2, col_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0]  acc_q, sum;
	logic signed [SH_W-1:0]   sh;
	logic signed [VAL_W-1:0]  sat;
	logic                     out_full_q;

	assign wr_addr    = ADDR_W'(cmd.wr_row * DIM + cmd.wr_col);
	assign left_addr  = ADDR_W'(cmd.row * DIM + cmd.k);
	assign right_addr = ADDR_W'(cmd.k * DIM + cmd.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM * DIM; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_left) begin
				left_q[wr_addr] <= cmd.wr_data;
			end
			if (cmd.wr_right) begin
				right_q[wr_addr] <= cmd.wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_valid;
			valid_s2 <= valid_s1;
			if (valid_s2 && last_s2) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= left_q[left_addr];
		b_s1     <= right_q[right_addr];
		first_s1 <= cmd.mac_first;
		last_s1  <= cmd.mac_last;
		elast_s1 <= cmd.elem_last;
		row_s1   <= cmd.row;
		col_s1   <= cmd.col;

		prod_s2  <= a_s1 * b_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		elast_s2 <= elast_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;

		if (valid_s2) begin
			acc_q <= sum;
		end
		if (valid_s2 && last_s2) begin
			product_value <= sat;
			out_row       <= row_s2;
			out_col       <= col_s2;
			last_element  <= elast_s2;
		end
	end

	always_comb begin
		sum = (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
		sh  = SH_W'(sum >>> FRAC_W);
		if (sh > SH_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (sh < -SH_W'(signed'({1'b0, 1'b1, {(VAL_W-1){1'b0}}}))) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = sh[VAL_W-1:0];
		end
	end

	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_full  = out_full_q;
	assign out_valid        = out_full_q;

endmodule

// File: rtl/mm4_checker.sv
module mm4_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [mm4_pkg::FUNC_W-1:0]   s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mm4_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         m_tlast
);
	import mm4_pkg::*;

	logic [IDX_W-1:0] m_row, m_col;

	assign m_row = m_tdata[IDX_W-1:0];
	assign m_col = m_tdata[2*IDX_W-1:IDX_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FN_COMPUTE |=> !s_tready)
		else $error("input taken right after a compute word");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FN_LOAD_LEFT || s_tuser == FN_LOAD_RIGHT)
		|=> s_tready)
		else $error("load word left the block busy");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == (m_row == IDX_W'(DIM - 1) && m_col == IDX_W'(DIM - 1)))
		else $error("tlast not on the final element");

endmodule

bind matrix_multiply_4x4_unit mm4_checker u_mm4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: tb/tb_matrix_multiply_4x4_unit.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_4x4_unit;

	import mm4_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam logic signed [127:0] Q_MAX = 128'sh7fff_ffff;
	localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [VAL_W-1:0]  value;
		bit                drain;
	} mm_word_t;

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             last;
	} product_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [FUNC_W-1:0]   s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	mm_word_t pending[$];
	product_t products_due[$];
	mm_word_t on_bus;

	logic signed [VAL_W-1:0] left_m  [DIM*DIM] = '{default: '0};
	logic signed [VAL_W-1:0] right_m [DIM*DIM] = '{default: '0};

	int words_accepted = 0;
	int total_words    = 0;
	int errors         = 0;
	int send_gap       = 0;
	int recv_stall     = 0;

	matrix_multiply_4x4_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value(int mix);
		int sel;
		sel = $urandom_range(0, 9);
		if (mix == 1)
			return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		if (mix == 2 && sel < 4) begin
			case (sel)
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0000;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [VAL_W-1:0] dot_q16(int r, int c);
		logic signed [127:0] acc;
		logic signed [PROD_W-1:0] term;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			term = left_m[r*DIM+k] * right_m[k*DIM+c];
			acc = acc + term;
		end
		acc = acc >>> FRAC_W;
		if (acc > Q_MAX)
			return 32'h7fff_ffff;
		if (acc < Q_MIN)
			return 32'h8000_0000;
		return acc[VAL_W-1:0];
	endfunction

	task automatic predict_word(mm_word_t w);
		product_t p;
		case (w.func)
			FN_LOAD_LEFT:  left_m[w.row*DIM+w.col] = w.value;
			FN_LOAD_RIGHT: right_m[w.row*DIM+w.col] = w.value;
			FN_COMPUTE: begin
				for (int c = 0; c < DIM; c++) begin
					for (int r = 0; r < DIM; r++) begin
						p.row   = IDX_W'(r);
						p.col   = IDX_W'(c);
						p.value = dot_q16(r, c);
						p.last  = (r == DIM - 1) && (c == DIM - 1);
						products_due.push_back(p);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_word(logic [FUNC_W-1:0] func, int row, int col,
			logic [VAL_W-1:0] value, bit drain = 1'b0);
		mm_word_t w;
		w.func  = func;
		w.row   = IDX_W'(row);
		w.col   = IDX_W'(col);
		w.value = value;
		w.drain = drain;
		pending.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_word(on_bus);
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && products_due.size() > 0)) begin
					on_bus = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, on_bus.value, on_bus.col, on_bus.row};
					s_tuser  <= on_bus.func;
					send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		product_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (products_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: row %0d col %0d value %h last %b",
							m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
					errors++;
				end else begin
					want = products_due.pop_front();
					if (m_tdata[1:0] !== want.row || m_tdata[3:2] !== want.col ||
							m_tdata[35:4] !== want.value || m_tlast !== want.last) begin
						if (errors < 10) begin
							$display("mismatch: expected row %0d col %0d value %h last %b",
								want.row, want.col, want.value, want.last);
							$display("          got      row %0d col %0d value %h last %b",
								m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
						end
						errors++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = pick_gap();
			end
		end
	end

	initial begin
		int mode;
		int mix;
		int n;
		for (int k = 0; k < DIM; k++)
			queue_word(FN_LOAD_LEFT, 0, k, 32'h7fff_ffff);
		queue_word(FN_COMPUTE, 3, 3, 32'hffff_ffff);
		queue_word(FN_UNUSED, 3, 3, 32'h7fff_ffff);
		for (int k = 0; k < DIM; k++)
			queue_word(FN_LOAD_RIGHT, k, 0, 32'h7fff_ffff);
		for (int k = 0; k < DIM; k++)
			queue_word(FN_LOAD_LEFT, 1, k, 32'h8000_0000);
		queue_word(FN_LOAD_RIGHT, 3, 3, 32'h8000_0000);
		queue_word(FN_LOAD_LEFT, 3, 3, 32'hffff_ffff);
		queue_word(FN_LOAD_LEFT, 2, 2, 32'hffff_ffff);
		queue_word(FN_LOAD_RIGHT, 2, 1, 32'h0000_0001);
		queue_word(FN_COMPUTE, 0, 0, 32'h0000_0000);
		queue_word(FN_UNUSED, 0, 0, 32'h0000_0000, 1'b1);
		queue_word(FN_UNUSED, 2, 1, 32'h5555_aaaa);
		queue_word(FN_COMPUTE, 1, 2, 32'haaaa_5555);

		while (pending.size() < 410) begin
			mode = $urandom_range(0, 99);
			mix  = $urandom_range(0, 2);
			if (mode < 15) begin
				for (int i = 0; i < DIM * DIM; i++)
					queue_word(FN_LOAD_LEFT, i / DIM, i % DIM, pick_value(mix));
				for (int i = 0; i < DIM * DIM; i++)
					queue_word(FN_LOAD_RIGHT, i / DIM, i % DIM, pick_value(mix));
				queue_word(FN_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom());
			end else if (mode < 70) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					queue_word(FUNC_W'($urandom_range(0, 1)), $urandom_range(0, 3),
						$urandom_range(0, 3), pick_value(mix));
				queue_word(FN_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom(),
					$urandom_range(0, 19) == 0);
			end else begin
				queue_word(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 3),
					$urandom_range(0, 3), pick_value(mix));
			end
		end
		total_words = pending.size();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (words_accepted < total_words)
			@(posedge clk);
		while (products_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && products_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
